// File: rtl/spvd_pkg.sv
package spvd_pkg;

	// Decoder phase
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ELLIPSE,
		PH_POINT,
		PH_POLY_START,
		PH_POLY_PAIRS
	} phase_t;

	// Record kinds
	localparam logic [1:0] KIND_POINT   = 2'd0;
	localparam logic [1:0] KIND_ELLIPSE = 2'd1;
	localparam logic [1:0] KIND_VERTEX  = 2'd2;

	// Header bit that selects an ellipse
	localparam int HDR_ELLIPSE_BIT = 7;

	// Byte positions inside the big-endian start words
	localparam logic [2:0] IDX_X_LO  = 3'd1;
	localparam logic [2:0] IDX_Y_LO  = 3'd3;
	localparam logic [2:0] IDX_RX_LO = 3'd5;
	localparam logic [2:0] IDX_RY_LO = 3'd7;

	// Output queue
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] radius_x;
		logic [15:0] radius_y;
		logic [7:0]  color;
		logic        alpha;
		logic        last;
	} rec_t;

	function automatic logic [15:0] sext8(input logic [7:0] v);
		return {{8{v[7]}}, v};
	endfunction

endpackage

// File: rtl/spvd_chan_if.sv
interface spvd_in_if;
	logic              valid;
	logic              ready;
	logic [7:0]        data_byte;
	logic              first_byte;
	logic signed [15:0] origin_x;
	logic signed [15:0] origin_y;
	logic [7:0]        prim_color;
	logic              alpha_flag;

	modport source (output valid, data_byte, first_byte, origin_x, origin_y,
		prim_color, alpha_flag, input ready);
	modport sink (input valid, data_byte, first_byte, origin_x, origin_y,
		prim_color, alpha_flag, output ready);
endinterface

interface spvd_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [15:0]        radius_x;
	logic [15:0]        radius_y;
	logic [7:0]         out_color;
	logic               out_alpha;
	logic               last;

	modport source (output valid, kind, pos_x, pos_y, radius_x, radius_y,
		out_color, out_alpha, last, input ready);
	modport sink (input valid, kind, pos_x, pos_y, radius_x, radius_y,
		out_color, out_alpha, last, output ready);
endinterface

// File: rtl/shape_primitive_vertex_decoder_unit.sv
// Shape primitive vertex decoder.
// Channel "bytes" carries the encoded primitive one byte per transfer; the
// header transfer has first_byte set and also carries origin, colour and
// alpha, which are held for the whole primitive. Channel "records" returns
// point, ellipse and polygon-vertex records, last set on the final one.
// Timing: a byte transfer is registered in the input stage, decoded from
// there once the queue has room, and its records are written into a
// four-entry result queue, visible on "records" in the cycle after the write.
// One byte is taken per cycle while the queue has room; the final pair of a
// polygon may write two records, and the queue drains one record per cycle
// while the receiver is ready, so the output transfer rate bounds the rate.
// The input stage moves on only when the queue has two free entries; when
// the receiver stalls, the queue fills and bytes.ready drops, no record is
// lost. Reset clears the input stage, the queue and the decoder state, which
// then waits for a header byte; bytes without first_byte while idle are
// dropped.
module shape_primitive_vertex_decoder_unit (
	input  logic              clk,
	input  logic              arst_n,
	spvd_in_if.sink           bytes,
	spvd_out_if.source        records
);
	import spvd_pkg::*;

	// Input stage
	logic              v_s1;
	logic [7:0]        data_s1;
	logic              first_s1;
	logic [15:0]       org_x_s1;
	logic [15:0]       org_y_s1;
	logic [7:0]        color_s1;
	logic              alpha_s1;

	// Decoder state
	phase_t            phase_q, phase_n;
	logic [2:0]        idx_q, idx_n;
	logic [6:0]        pairs_q, pairs_n;
	logic [7:0]        hold_q, hold_n;
	logic [15:0]       run_x_q, run_x_n;
	logic [15:0]       run_y_q, run_y_n;
	logic [15:0]       base_x_q, base_x_n;
	logic [15:0]       base_y_q, base_y_n;
	logic [15:0]       rad_q, rad_n;
	logic [7:0]        pdx_q, pdx_n;
	logic [7:0]        pdy_q, pdy_n;
	logic              pend_q, pend_n;
	logic [7:0]        color_q, color_n;
	logic              alpha_q, alpha_n;

	// Result queue
	rec_t              rq_q [RQ_DEPTH];
	logic [RQ_AW-1:0]  wr_ptr_q;
	logic [RQ_AW-1:0]  rd_ptr_q;
	logic [RQ_AW:0]    cnt_q;

	logic              fire;
	logic              pop;
	logic              rec_a_v, rec_b_v;
	rec_t              rec_a, rec_b, push_first;
	logic [1:0]        push_n;
	logic [15:0]       word;
	logic [15:0]       rx1, ry1, rx2, ry2;
	logic [6:0]        pairs_dec;
	rec_t              head;

	// Stage advances when the queue can take two records
	assign fire        = v_s1 && (cnt_q <= (RQ_AW+1)'(RQ_DEPTH - 2));
	assign bytes.ready = !v_s1 || fire;
	assign pop         = records.valid && records.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (bytes.ready) begin
			v_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			data_s1  <= bytes.data_byte;
			first_s1 <= bytes.first_byte;
			org_x_s1 <= bytes.origin_x;
			org_y_s1 <= bytes.origin_y;
			color_s1 <= bytes.prim_color;
			alpha_s1 <= bytes.alpha_flag;
		end
	end

	assign word      = {hold_q, data_s1};
	assign pairs_dec = pairs_q - 7'd1;

	// Byte decode: next state and up to two records
	always_comb begin
		phase_n  = phase_q;
		idx_n    = idx_q;
		pairs_n  = pairs_q;
		hold_n   = hold_q;
		run_x_n  = run_x_q;
		run_y_n  = run_y_q;
		base_x_n = base_x_q;
		base_y_n = base_y_q;
		rad_n    = rad_q;
		pdx_n    = pdx_q;
		pdy_n    = pdy_q;
		pend_n   = pend_q;
		color_n  = color_q;
		alpha_n  = alpha_q;
		rec_a_v  = 1'b0;
		rec_b_v  = 1'b0;
		rx1      = run_x_q;
		ry1      = run_y_q;
		rx2      = run_x_q;
		ry2      = run_y_q;
		rec_a    = '{kind: KIND_VERTEX, pos_x: run_x_q + base_x_q,
			pos_y: run_y_q + base_y_q, radius_x: '0, radius_y: '0,
			color: color_q, alpha: alpha_q, last: 1'b0};
		rec_b    = rec_a;

		if (fire) begin
			if (first_s1) begin
				// Header: latch primitive attributes
				base_x_n = org_x_s1;
				base_y_n = org_y_s1;
				color_n  = color_s1;
				alpha_n  = alpha_s1;
				idx_n    = '0;
				pend_n   = 1'b0;
				if (data_s1[HDR_ELLIPSE_BIT]) begin
					phase_n = PH_ELLIPSE;
				end else if (data_s1 == 8'd0) begin
					phase_n = PH_POINT;
				end else begin
					phase_n = PH_POLY_START;
					pairs_n = data_s1[6:0];
				end
			end else begin
				unique case (phase_q)
					PH_ELLIPSE, PH_POINT, PH_POLY_START: begin
						if (!idx_q[0]) begin
							hold_n = data_s1;
							idx_n  = idx_q + 3'd1;
						end else begin
							idx_n = idx_q + 3'd1;
							case (idx_q)
								IDX_X_LO: run_x_n = word;
								IDX_Y_LO: begin
									run_y_n = word;
									rec_a.pos_y = word + base_y_q;
									if (phase_q == PH_POINT) begin
										rec_a_v    = 1'b1;
										rec_a.kind = KIND_POINT;
										rec_a.last = 1'b1;
										phase_n    = PH_IDLE;
										idx_n      = '0;
									end else if (phase_q == PH_POLY_START) begin
										rec_a_v = 1'b1;
										phase_n = PH_POLY_PAIRS;
										pend_n  = 1'b0;
										idx_n   = '0;
									end
								end
								IDX_RX_LO: rad_n = word;
								default: begin
									// radius y completes the ellipse
									rec_a_v        = 1'b1;
									rec_a.kind     = KIND_ELLIPSE;
									rec_a.radius_x = rad_q;
									rec_a.radius_y = word;
									rec_a.last     = 1'b1;
									phase_n        = PH_IDLE;
									idx_n          = '0;
								end
							endcase
						end
					end
					PH_POLY_PAIRS: begin
						if (!idx_q[0]) begin
							hold_n = data_s1;
							idx_n  = 3'd1;
						end else begin
							idx_n = '0;
							// Resolve the pending pair; flat runs merge
							if (pend_q) begin
								rx1 = run_x_q + sext8(pdx_q);
								if (!(pdy_q == 8'd0 && data_s1 == 8'd0)) begin
									ry1     = run_y_q + sext8(pdy_q);
									rec_a_v = 1'b1;
								end
							end
							rec_a.pos_x = rx1 + base_x_q;
							rec_a.pos_y = ry1 + base_y_q;
							pairs_n = pairs_dec;
							if (pairs_dec == 7'd0) begin
								// Final pair is never merged
								rx2         = rx1 + sext8(hold_q);
								ry2         = ry1 + sext8(data_s1);
								rec_b_v     = 1'b1;
								rec_b.pos_x = rx2 + base_x_q;
								rec_b.pos_y = ry2 + base_y_q;
								rec_b.last  = 1'b1;
								pend_n      = 1'b0;
								phase_n     = PH_IDLE;
							end else begin
								pdx_n  = hold_q;
								pdy_n  = data_s1;
								pend_n = 1'b1;
							end
							run_x_n = rx2;
							run_y_n = ry2;
							if (pairs_dec != 7'd0) begin
								run_x_n = rx1;
								run_y_n = ry1;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			idx_q    <= '0;
			pairs_q  <= '0;
			hold_q   <= '0;
			run_x_q  <= '0;
			run_y_q  <= '0;
			base_x_q <= '0;
			base_y_q <= '0;
			rad_q    <= '0;
			pdx_q    <= '0;
			pdy_q    <= '0;
			pend_q   <= 1'b0;
			color_q  <= '0;
			alpha_q  <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			idx_q    <= idx_n;
			pairs_q  <= pairs_n;
			hold_q   <= hold_n;
			run_x_q  <= run_x_n;
			run_y_q  <= run_y_n;
			base_x_q <= base_x_n;
			base_y_q <= base_y_n;
			rad_q    <= rad_n;
			pdx_q    <= pdx_n;
			pdy_q    <= pdy_n;
			pend_q   <= pend_n;
			color_q  <= color_n;
			alpha_q  <= alpha_n;
		end
	end

	// Queue write: resolved pending vertex first, then the final one
	assign push_first = rec_a_v ? rec_a : rec_b;
	assign push_n     = {1'b0, rec_a_v} + {1'b0, rec_b_v};

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			rq_q[wr_ptr_q] <= push_first;
		end
		if (push_n == 2'd2) begin
			rq_q[wr_ptr_q + RQ_AW'(1)] <= rec_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_AW'(push_n);
			rd_ptr_q <= rd_ptr_q + RQ_AW'(pop);
			cnt_q    <= cnt_q + (RQ_AW+1)'(push_n) - (RQ_AW+1)'(pop);
		end
	end

	// Queue head drives the result channel
	assign head              = rq_q[rd_ptr_q];
	assign records.valid     = (cnt_q != '0);
	assign records.kind      = head.kind;
	assign records.pos_x     = head.pos_x;
	assign records.pos_y     = head.pos_y;
	assign records.radius_x  = head.radius_x;
	assign records.radius_y  = head.radius_y;
	assign records.out_color = head.color;
	assign records.out_alpha = head.alpha;
	assign records.last      = head.last;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (RQ_AW+1)'(RQ_DEPTH))
		else $error("result queue overflow");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q + (RQ_AW+1)'(push_n) - (RQ_AW+1)'(pop)))
		else $error("queue count out of step with writes and reads");

	a_hdr_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && first_s1) |-> (push_n == 2'd0))
		else $error("header byte produced a record");

	a_pend_phase: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (phase_q == PH_POLY_PAIRS))
		else $error("pending pair outside polygon pairs");

	a_pair_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_POLY_PAIRS) |-> (idx_q[2:1] == 2'b00))
		else $error("byte index out of range in pair phase");

endmodule

// File: dv/tb_top.sv
module tb_top;
	import spvd_pkg::*;

	localparam int STREAM_BYTES = 1300;
	localparam int CALM_FROM    = 900;
	localparam int CALM_TO      = 1400;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 20;

	// One byte of the encoded stream plus the header-side fields
	typedef struct {
		logic [7:0]  data;
		logic        first;
		logic [15:0] ox;
		logic [15:0] oy;
		logic [7:0]  color;
		logic        alpha;
		bit          drain_first;
	} shape_byte_t;

	logic clk;
	logic arst_n;

	spvd_in_if  bytes_if ();
	spvd_out_if rec_if ();

	shape_primitive_vertex_decoder_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes_if),
		.records (rec_if)
	);

	shape_byte_t byte_stream[$];
	rec_t        pending_records[$];
	shape_byte_t on_wire;

	int cycle_no;
	int bytes_total;
	int bytes_taken;
	int recs_seen;
	int errors;
	int stall_left;
	bit stall_done;
	int n_points, n_ellipses, n_polys, n_cut, n_noise;

	// Decoder state as seen by the predictor
	phase_t      dec_phase;
	logic [2:0]  dec_idx;
	logic [6:0]  dec_pairs;
	logic [7:0]  dec_hi;
	logic [15:0] cur_x, cur_y, org_x, org_y, rad_x_hold;
	logic [7:0]  held_dx, held_dy, held_color;
	logic        held_valid, held_alpha;

	always #5 clk = ~clk;

	always @(posedge clk) cycle_no <= cycle_no + 1;

	function automatic bit side_idle();
		if (cycle_no >= CALM_FROM && cycle_no < CALM_TO)
			return 1'b0;
		return $urandom_range(0, 99) < 25;
	endfunction

	function automatic logic [15:0] step_of(input logic [7:0] d);
		return {{8{d[7]}}, d};
	endfunction

	function automatic void emit_record(input logic [1:0] k, input logic [15:0] rx,
		input logic [15:0] ry, input logic fin);
		rec_t r;
		r.kind     = k;
		r.pos_x    = cur_x + org_x;
		r.pos_y    = cur_y + org_y;
		r.radius_x = rx;
		r.radius_y = ry;
		r.color    = held_color;
		r.alpha    = held_alpha;
		r.last     = fin;
		pending_records.push_back(r);
	endfunction

	// Predict the records caused by one accepted byte
	function automatic void decode_byte(input shape_byte_t it);
		logic [15:0] word;
		logic [7:0]  b;
		b = it.data;
		if (it.first) begin
			org_x      = it.ox;
			org_y      = it.oy;
			held_color = it.color;
			held_alpha = it.alpha;
			dec_idx    = 3'd0;
			held_valid = 1'b0;
			if (b[HDR_ELLIPSE_BIT])
				dec_phase = PH_ELLIPSE;
			else if (b == 8'd0)
				dec_phase = PH_POINT;
			else begin
				dec_phase = PH_POLY_START;
				dec_pairs = b[6:0];
			end
		end else begin
			case (dec_phase)
				PH_ELLIPSE, PH_POINT, PH_POLY_START: begin
					if (!dec_idx[0]) begin
						dec_hi  = b;
						dec_idx = dec_idx + 3'd1;
					end else begin
						word = {dec_hi, b};
						case (dec_idx)
							IDX_X_LO: begin
								cur_x   = word;
								dec_idx = dec_idx + 3'd1;
							end
							IDX_Y_LO: begin
								cur_y = word;
								if (dec_phase == PH_POINT) begin
									emit_record(KIND_POINT, 16'd0, 16'd0, 1'b1);
									dec_phase = PH_IDLE;
									dec_idx   = 3'd0;
								end else if (dec_phase == PH_POLY_START) begin
									emit_record(KIND_VERTEX, 16'd0, 16'd0, 1'b0);
									dec_phase  = PH_POLY_PAIRS;
									held_valid = 1'b0;
									dec_idx    = 3'd0;
								end else begin
									dec_idx = dec_idx + 3'd1;
								end
							end
							IDX_RX_LO: begin
								rad_x_hold = word;
								dec_idx    = dec_idx + 3'd1;
							end
							default: begin
								emit_record(KIND_ELLIPSE, rad_x_hold, word, 1'b1);
								dec_phase = PH_IDLE;
								dec_idx   = 3'd0;
							end
						endcase
					end
				end
				PH_POLY_PAIRS: begin
					if (!dec_idx[0]) begin
						dec_hi  = b;
						dec_idx = 3'd1;
					end else begin
						dec_idx = 3'd0;
						// resolve the held pair now that the next dy is known
						if (held_valid) begin
							cur_x = cur_x + step_of(held_dx);
							if (!(held_dy == 8'd0 && b == 8'd0)) begin
								cur_y = cur_y + step_of(held_dy);
								emit_record(KIND_VERTEX, 16'd0, 16'd0, 1'b0);
							end
						end
						held_dx    = dec_hi;
						held_dy    = b;
						held_valid = 1'b1;
						dec_pairs  = dec_pairs - 7'd1;
						// final pair is never merged
						if (dec_pairs == 7'd0) begin
							cur_x = cur_x + step_of(held_dx);
							cur_y = cur_y + step_of(held_dy);
							emit_record(KIND_VERTEX, 16'd0, 16'd0, 1'b1);
							held_valid = 1'b0;
							dec_phase  = PH_IDLE;
						end
					end
				end
				default: ;
			endcase
		end
	endfunction

	// Stimulus building
	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h7FFF;
			3: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] rand_delta();
		case ($urandom_range(0, 9))
			0: return 8'h7F;
			1: return 8'h80;
			2: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [6:0] rand_pairs();
		int r;
		r = $urandom_range(0, 99);
		if (r < 1)
			return 7'd127;
		if (r < 3)
			return 7'($urandom_range(9, 126));
		return 7'($urandom_range(1, 8));
	endfunction

	task automatic add_data(input logic [7:0] b);
		shape_byte_t s;
		s.data        = b;
		s.first       = 1'b0;
		s.ox          = 16'($urandom);
		s.oy          = 16'($urandom);
		s.color       = 8'($urandom);
		s.alpha       = 1'($urandom);
		s.drain_first = 1'b0;
		byte_stream.push_back(s);
	endtask

	task automatic add_header(input logic [7:0] b, input logic [15:0] ox, input logic [15:0] oy,
		input logic [7:0] col, input logic a, input bit drain);
		shape_byte_t s;
		s.data        = b;
		s.first       = 1'b1;
		s.ox          = ox;
		s.oy          = oy;
		s.color       = col;
		s.alpha       = a;
		s.drain_first = drain;
		byte_stream.push_back(s);
	endtask

	task automatic rand_header(input logic [7:0] b, input bit drain);
		logic [7:0] col;
		logic       a;
		col = 8'($urandom);
		a   = 1'($urandom);
		add_header(b, rand_word(), rand_word(), col, a, drain);
	endtask

	task automatic add_word(input logic [15:0] w);
		add_data(w[15:8]);
		add_data(w[7:0]);
	endtask

	task automatic gen_polygon(input logic [6:0] n, input bit drain);
		logic [7:0] dy;
		rand_header({1'b0, n}, drain);
		add_word(rand_word());
		add_word(rand_word());
		repeat (n) begin
			dy = ($urandom_range(0, 99) < 45) ? 8'h00 : rand_delta();
			add_data(rand_delta());
			add_data(dy);
		end
	endtask

	task automatic gen_random_prim();
		int         pick, start;
		bit         drain;
		logic [7:0] hdr;
		pick  = $urandom_range(0, 99);
		start = byte_stream.size();
		drain = ($urandom_range(0, 99) < 3);
		if (pick < 8) begin
			n_noise++;
			repeat ($urandom_range(1, 3)) add_data(8'($urandom));
		end else begin
			if (pick < 35) begin
				n_points++;
				rand_header(8'h00, drain);
				add_word(rand_word());
				add_word(rand_word());
			end else if (pick < 60) begin
				n_ellipses++;
				hdr    = 8'($urandom);
				hdr[7] = 1'b1;
				rand_header(hdr, drain);
				repeat (4) add_word(rand_word());
			end else begin
				n_polys++;
				gen_polygon(rand_pairs(), drain);
			end
			// now and then cut the primitive short; the next header abandons it
			if ($urandom_range(0, 99) < 8) begin
				n_cut++;
				repeat ($urandom_range(1, byte_stream.size() - start - 1))
					byte_stream.delete(byte_stream.size() - 1);
			end
		end
	endtask

	// Byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_if.valid <= 1'b0;
		end else begin
			if (bytes_if.valid && bytes_if.ready) begin
				decode_byte(on_wire);
				bytes_taken++;
			end
			if (!(bytes_if.valid && !bytes_if.ready)) begin
				if (byte_stream.size() != 0 && !side_idle()
						&& !(byte_stream[0].drain_first && pending_records.size() != 0)) begin
					on_wire = byte_stream.pop_front();
					bytes_if.valid      <= 1'b1;
					bytes_if.data_byte  <= on_wire.data;
					bytes_if.first_byte <= on_wire.first;
					bytes_if.origin_x   <= on_wire.ox;
					bytes_if.origin_y   <= on_wire.oy;
					bytes_if.prim_color <= on_wire.color;
					bytes_if.alpha_flag <= on_wire.alpha;
				end else begin
					bytes_if.valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("record %0d: %s expected %0h, got %0h", recs_seen, name, want, got);
			errors++;
		end
	endfunction

	// Record monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_if.ready <= 1'b0;
		end else begin
			if (rec_if.valid && rec_if.ready) begin
				if (pending_records.size() == 0) begin
					$error("record %0d: transfer with no record expected", recs_seen);
					errors++;
				end else begin
					check_field("kind", 16'(pending_records[0].kind), 16'(rec_if.kind));
					check_field("pos_x", pending_records[0].pos_x, rec_if.pos_x);
					check_field("pos_y", pending_records[0].pos_y, rec_if.pos_y);
					check_field("radius_x", pending_records[0].radius_x, rec_if.radius_x);
					check_field("radius_y", pending_records[0].radius_y, rec_if.radius_y);
					check_field("out_color", 16'(pending_records[0].color),
						16'(rec_if.out_color));
					check_field("out_alpha", 16'(pending_records[0].alpha),
						16'(rec_if.out_alpha));
					check_field("last", 16'(pending_records[0].last), 16'(rec_if.last));
					pending_records.delete(0);
				end
				recs_seen++;
			end
			// one long hold-off so the result queue fills and bytes.ready drops
			if (!stall_done && recs_seen >= HOLD_AT) begin
				stall_left = HOLD_CYCLES;
				stall_done = 1'b1;
			end
			if (stall_left != 0) begin
				stall_left--;
				rec_if.ready <= 1'b0;
			end else begin
				rec_if.ready <= !side_idle();
			end
		end
	end

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		cycle_no   = 0;
		bytes_taken = 0;
		recs_seen  = 0;
		errors     = 0;
		stall_left = 0;
		stall_done = 1'b0;
		n_points = 0; n_ellipses = 0; n_polys = 0; n_cut = 0; n_noise = 0;
		dec_phase  = PH_IDLE;
		dec_idx    = '0;
		dec_pairs  = '0;
		dec_hi     = '0;
		cur_x = '0; cur_y = '0; org_x = '0; org_y = '0; rad_x_hold = '0;
		held_dx = '0; held_dy = '0; held_color = '0;
		held_valid = 1'b0; held_alpha = 1'b0;

		// Directed: stray byte while idle
		add_data(8'h55);
		// point with extreme origin, coordinates wrap
		add_header(8'h00, 16'h7FFF, 16'h8000, 8'hFF, 1'b1, 1'b0);
		add_word(16'hFFFF);
		add_word(16'h0001);
		// stray byte after a finished primitive
		add_data(8'hAA);
		// ellipse abandoned by a new header
		add_header(8'h81, 16'h1234, 16'h5678, 8'h3C, 1'b0, 1'b0);
		add_data(8'h12);
		// ellipse with extreme centre and radii
		add_header(8'hFF, 16'h8000, 16'h7FFF, 8'h00, 1'b0, 1'b0);
		add_word(16'h8000);
		add_word(16'h7FFF);
		add_word(16'hFFFF);
		add_word(16'h0000);
		// polygon: horizontal merge, then two records on the last pair
		add_header(8'h03, 16'h0000, 16'hFFFF, 8'hA5, 1'b1, 1'b0);
		add_word(16'h0000);
		add_word(16'h0000);
		add_data(8'h7F); add_data(8'h00);
		add_data(8'h80); add_data(8'h00);
		add_data(8'h01); add_data(8'h80);

		// Random: one full-length polygon after a drain, then a mix
		n_polys++;
		gen_polygon(7'd127, 1'b1);
		while (byte_stream.size() < STREAM_BYTES)
			gen_random_prim();
		bytes_total = byte_stream.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (bytes_taken != bytes_total)
			@(posedge clk);
		while (pending_records.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("summary: %0d bytes sent, %0d records checked", bytes_taken, recs_seen);
		$display("summary: %0d points, %0d ellipses, %0d polygons, %0d cut short, %0d noise runs",
			n_points, n_ellipses, n_polys, n_cut, n_noise);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
